>>> sv/cchc_pkg.sv
`timescale 1ns / 1ps

package cchc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_STEP_COST   = 2'd2,
        REG_DIAG_COST   = 2'd3
    } cfg_reg_t;

    localparam int COST_BITS = 16;
    localparam int DIM_BITS  = 9;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_CLAMP = 3'b100
    } seq_state_t;

endpackage

>>> sv/cchc_store.sv
`timescale 1ns / 1ps

// Ceiling and height/seed memories, one write and one registered read port each.
module cchc_store
    import cchc_pkg::*;
#(
    parameter int AW = 16,
    parameter int HB = 24
)
(
    input  logic                 clk,
    input  logic                 c_we,
    input  logic [AW-1:0]        c_waddr,
    input  logic signed [HB:0]   c_wdata,
    input  logic [AW-1:0]        c_raddr,
    output logic signed [HB:0]   c_rdata,
    input  logic                 h_we,
    input  logic [AW-1:0]        h_waddr,
    input  logic [HB:0]          h_wdata,
    input  logic [AW-1:0]        h_raddr,
    output logic [HB:0]          h_rdata
);

    logic signed [HB:0] ceil_mem [2**AW];
    logic [HB:0]        hgt_mem  [2**AW];

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            ceil_mem[c_waddr] <= c_wdata;
        end
        c_rdata <= ceil_mem[c_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hgt_mem[h_waddr] <= h_wdata;
        end
        h_rdata <= hgt_mem[h_raddr];
    end

endmodule

>>> sv/cchc_seq.sv
`timescale 1ns / 1ps

// Sweep and clamp sequencer: read-modify-write over the ceiling memory.
module cchc_seq
    import cchc_pkg::*;
#(
    parameter int AW = 16,
    parameter int HB = 24,
    parameter int WW = 9,
    parameter int HW = 9,
    parameter int NB = 18,
    parameter int SWEEP_PAIRS = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [WW-1:0]           eff_w,
    input  logic [HW-1:0]           eff_h,
    input  logic [NB-1:0]           n_nodes,
    input  logic [COST_BITS-1:0]    step_cost,
    input  logic [COST_BITS-1:0]    diag_cost,
    output logic                    busy,
    output logic                    c_we,
    output logic [AW-1:0]           c_waddr,
    output logic signed [HB:0]      c_wdata,
    output logic [AW-1:0]           c_raddr,
    input  logic signed [HB:0]      c_rdata,
    output logic                    h_we,
    output logic [AW-1:0]           h_waddr,
    output logic [HB:0]             h_wdata,
    output logic [AW-1:0]           h_raddr,
    input  logic [HB:0]             h_rdata
);

    localparam int CW = HB + 1;
    localparam int PB = $clog2(SWEEP_PAIRS + 1);
    localparam logic signed [CW-1:0] INF = {1'b0, {HB{1'b1}}};

    seq_state_t state_reg, state_next;
    logic [2:0]      k_reg, k_next;
    logic [WW-1:0]   x_reg, x_next;
    logic [HW-1:0]   y_reg, y_next;
    logic            bwd_reg, bwd_next;
    logic [PB-1:0]   pair_reg, pair_next;
    logic [AW-1:0]   ca_reg, ca_next;
    logic            ph_reg, ph_next;
    logic            pc_reg, pc_next;    // pending read is the center
    logic            pv_reg, pv_next;    // pending read is a real neighbor
    logic            pd_reg, pd_next;    // pending neighbor is diagonal
    logic signed [CW-1:0] acc_reg, acc_next;

    logic [AW-1:0]   wa;
    logic            x_lo, x_hi, y_lo, y_hi;
    logic            nb_ok, nb_diag;
    logic [AW-1:0]   nb_addr;
    logic signed [CW:0]   sum;
    logic signed [CW-1:0] relaxed, acc_comb;
    logic [AW-1:0]   last_addr;

    assign wa        = AW'(eff_w);
    assign last_addr = n_nodes[AW-1:0] - AW'(1);
    assign x_lo      = (x_reg != '0);
    assign x_hi      = ({1'b0, x_reg} + (WW+1)'(1) < {1'b0, eff_w});
    assign y_lo      = (y_reg != '0);
    assign y_hi      = ({1'b0, y_reg} + (HW+1)'(1) < {1'b0, eff_h});

    // Neighbor chosen by k and sweep direction
    always_comb
    begin
        nb_ok   = 1'b0;
        nb_diag = 1'b0;
        nb_addr = ca_reg;
        case (k_reg)
            3'd1:
            begin
                nb_ok   = bwd_reg ? x_hi : x_lo;
                nb_addr = bwd_reg ? ca_reg + AW'(1) : ca_reg - AW'(1);
            end
            3'd2:
            begin
                nb_ok   = bwd_reg ? y_hi : y_lo;
                nb_addr = bwd_reg ? ca_reg + wa : ca_reg - wa;
            end
            3'd3:
            begin
                nb_diag = 1'b1;
                nb_ok   = bwd_reg ? (x_hi && y_hi) : (x_lo && y_lo);
                nb_addr = bwd_reg ? ca_reg + wa + AW'(1) : ca_reg - wa - AW'(1);
            end
            3'd4:
            begin
                nb_diag = 1'b1;
                nb_ok   = bwd_reg ? (x_lo && y_hi) : (x_hi && y_lo);
                nb_addr = bwd_reg ? ca_reg + wa - AW'(1) : ca_reg - wa + AW'(1);
            end
            default:
            begin
                nb_ok   = 1'b0;
            end
        endcase
    end

    // Saturating add of the returned neighbor ceiling, then the running min
    always_comb
    begin
        sum = {c_rdata[CW-1], c_rdata}
            + $signed({{(CW+1-COST_BITS){1'b0}}, pd_reg ? diag_cost : step_cost});
        if (c_rdata >= INF || sum > $signed({1'b0, INF}))
        begin
            relaxed = INF;
        end
        else
        begin
            relaxed = sum[CW-1:0];
        end
        acc_comb = acc_reg;
        if (pc_reg)
        begin
            acc_comb = c_rdata;
        end
        else if (pv_reg && relaxed < acc_reg)
        begin
            acc_comb = relaxed;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        bwd_next   = bwd_reg;
        pair_next  = pair_reg;
        ca_next    = ca_reg;
        ph_next    = ph_reg;
        pc_next    = 1'b0;
        pv_next    = 1'b0;
        pd_next    = nb_diag;
        acc_next   = acc_comb;
        c_we       = 1'b0;
        c_waddr    = ca_reg;
        c_wdata    = acc_comb;
        c_raddr    = (k_reg == 3'd0) ? ca_reg : nb_addr;
        h_we       = 1'b0;
        h_waddr    = ca_reg;
        h_wdata    = {h_rdata[HB], c_rdata[HB-1:0]};
        h_raddr    = ca_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SWEEP;
                    k_next     = '0;
                    x_next     = '0;
                    y_next     = '0;
                    bwd_next   = 1'b0;
                    pair_next  = '0;
                    ca_next    = '0;
                end
            end
            S_SWEEP:
            begin
                if (k_reg != 3'd5)
                begin
                    pc_next = (k_reg == 3'd0);
                    pv_next = nb_ok;
                    k_next  = k_reg + 3'd1;
                end
                else
                begin
                    c_we   = 1'b1;
                    k_next = '0;
                    if (!bwd_reg)
                    begin
                        ca_next = ca_reg + AW'(1);
                        if (!x_hi)
                        begin
                            x_next = '0;
                            if (!y_hi)
                            begin
                                bwd_next = 1'b1;
                                x_next   = eff_w - WW'(1);
                                y_next   = eff_h - HW'(1);
                                ca_next  = last_addr;
                            end
                            else
                            begin
                                y_next = y_reg + HW'(1);
                            end
                        end
                        else
                        begin
                            x_next = x_reg + WW'(1);
                        end
                    end
                    else
                    begin
                        ca_next = ca_reg - AW'(1);
                        if (!x_lo)
                        begin
                            x_next = eff_w - WW'(1);
                            if (!y_lo)
                            begin
                                pair_next = pair_reg + PB'(1);
                                bwd_next  = 1'b0;
                                x_next    = '0;
                                y_next    = '0;
                                ca_next   = '0;
                                ph_next   = 1'b0;
                                if (pair_reg + PB'(1) == PB'(SWEEP_PAIRS))
                                begin
                                    state_next = S_CLAMP;
                                end
                            end
                            else
                            begin
                                y_next = y_reg - HW'(1);
                            end
                        end
                        else
                        begin
                            x_next = x_reg - WW'(1);
                        end
                    end
                end
            end
            S_CLAMP:
            begin
                c_raddr = ca_reg;
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    // non-seed with a finite ceiling below its height
                    h_we = !h_rdata[HB] && c_rdata < INF
                        && c_rdata < $signed({h_rdata[HB-1], h_rdata[HB-1:0]});
                    if (ca_reg == last_addr)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ca_next = ca_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            bwd_reg   <= 1'b0;
            pair_reg  <= '0;
            ca_reg    <= '0;
            ph_reg    <= 1'b0;
            pc_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            bwd_reg   <= bwd_next;
            pair_reg  <= pair_next;
            ca_reg    <= ca_next;
            ph_reg    <= ph_next;
            pc_reg    <= pc_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pd_reg  <= pd_next;
        acc_reg <= acc_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> sv/chamfer_cone_height_clamp_unit.sv
`timescale 1ns / 1ps

// Channel  | handshake           | payload
// in       | in_valid/in_ready   | mode, node_height, seeded
// out      | out_valid/out_ready | out_height, last_node
// cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A load writes both memories as it is taken; a taken fetch sets pend_reg, then the result
// is registered in the output register. The load that fills the grid starts the sweeps
// (one ceiling-memory read port: center plus four neighbors, then write back, per node):
// 2*SWEEP_PAIRS sweeps, then a clamp pass that reads each node, then writes it if clamped. No request
// or register write is taken meanwhile. Reset clears indexes and flags, not the memories.
// A fetch is held off while a result waits in the output register.
module chamfer_cone_height_clamp_unit
    import cchc_pkg::*;
#(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int HEIGHT_BITS = 24,
    parameter int SWEEP_PAIRS = 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic signed [HEIGHT_BITS-1:0] node_height,
    input  logic                          seeded,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [HEIGHT_BITS-1:0] out_height,
    output logic                          last_node,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [COST_BITS-1:0]          cfg_data
);

    localparam int HB = HEIGHT_BITS;
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int NB = WW + HW;
    localparam logic signed [HB:0] INF = {1'b0, {HB{1'b1}}};

    // Configuration
    logic [DIM_BITS-1:0]  grid_width_reg, grid_height_reg;
    logic [COST_BITS-1:0] step_cost_reg, diag_cost_reg;

    // Read-out and load control
    logic [NB-1:0] load_idx_reg, load_idx_next;
    logic [NB-1:0] fetch_idx_reg, fetch_idx_next;
    logic          sweeps_done_reg, sweeps_done_next;
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;
    logic          out_valid_reg, out_valid_next;
    logic          last_reg;
    logic [HB-1:0] out_h_reg;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [NB-1:0] n_nodes;
    logic [NB-1:0] li_eff, fi_eff;
    logic          in_acc, ld_acc, ft_acc, start;
    logic          busy;

    logic                c_we_s, h_we_s;
    logic [AW-1:0]       c_waddr_s, c_raddr_s, h_waddr_s, h_raddr_s;
    logic signed [HB:0]  c_wdata_s;
    logic [HB:0]         h_wdata_s;

    logic                c_we, h_we;
    logic [AW-1:0]       c_waddr, c_raddr, h_waddr, h_raddr;
    logic signed [HB:0]  c_wdata, c_rdata;
    logic [HB:0]         h_wdata, h_rdata;

    // Effective grid size: zero acts as one, clipped to the maximum
    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(grid_width_reg);
        end
        if (grid_height_reg == '0)
        begin
            eff_h = HW'(1);
        end
        else if (32'(grid_height_reg) > 32'(MAX_HEIGHT))
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(grid_height_reg);
        end
    end

    assign n_nodes = NB'(eff_w) * NB'(eff_h);

    // grid size and costs stay fixed while the sweeps run
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_BITS'(256);
            grid_height_reg <= DIM_BITS'(256);
            step_cost_reg   <= COST_BITS'(256);
            diag_cost_reg   <= COST_BITS'(362);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[DIM_BITS-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[DIM_BITS-1:0];
                REG_STEP_COST:   step_cost_reg   <= cfg_data;
                REG_DIAG_COST:   diag_cost_reg   <= cfg_data;
                default:         grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    // A request waits while the sequencer runs, a fetch read is in flight,
    // or the output register holds a result that is not being taken.
    assign in_ready = !busy && !pend_reg && (!out_valid_reg || out_ready);
    assign in_acc   = in_valid && in_ready;
    assign ld_acc   = in_acc && !mode;
    assign ft_acc   = in_acc && mode;

    assign li_eff = (load_idx_reg >= n_nodes) ? '0 : load_idx_reg;
    assign fi_eff = (fetch_idx_reg >= n_nodes) ? '0 : fetch_idx_reg;
    assign start  = ld_acc && (li_eff + NB'(1) == n_nodes);

    always_comb
    begin
        load_idx_next    = load_idx_reg;
        fetch_idx_next   = fetch_idx_reg;
        sweeps_done_next = sweeps_done_reg;
        pend_next        = 1'b0;
        pend_last_next   = (fi_eff == n_nodes - NB'(1));
        out_valid_next   = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
        end
        if (ld_acc)
        begin
            load_idx_next    = li_eff + NB'(1);
            sweeps_done_next = start;
            if (start)
            begin
                fetch_idx_next = '0;
            end
        end
        if (ft_acc && sweeps_done_reg)
        begin
            pend_next      = 1'b1;
            fetch_idx_next = (fi_eff + NB'(1) >= n_nodes) ? '0 : fi_eff + NB'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg    <= '0;
            fetch_idx_reg   <= '0;
            sweeps_done_reg <= 1'b0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            load_idx_reg    <= load_idx_next;
            fetch_idx_reg   <= fetch_idx_next;
            sweeps_done_reg <= sweeps_done_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_last_reg <= pend_last_next;
        if (pend_reg)
        begin
            out_h_reg <= h_rdata[HB-1:0];
            last_reg  <= pend_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_height = out_h_reg;
    assign last_node  = last_reg;

    // Memory port arbitration: loads and fetches own the ports while idle
    assign c_we    = busy ? c_we_s : ld_acc;
    assign c_waddr = busy ? c_waddr_s : li_eff[AW-1:0];
    assign c_wdata = busy ? c_wdata_s : (seeded ? {node_height[HB-1], node_height} : INF);
    assign c_raddr = c_raddr_s;
    assign h_we    = busy ? h_we_s : ld_acc;
    assign h_waddr = busy ? h_waddr_s : li_eff[AW-1:0];
    assign h_wdata = busy ? h_wdata_s : {seeded, node_height};
    assign h_raddr = busy ? h_raddr_s : fi_eff[AW-1:0];

    cchc_seq #(
        .AW          (AW),
        .HB          (HB),
        .WW          (WW),
        .HW          (HW),
        .NB          (NB),
        .SWEEP_PAIRS (SWEEP_PAIRS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .n_nodes   (n_nodes),
        .step_cost (step_cost_reg),
        .diag_cost (diag_cost_reg),
        .busy      (busy),
        .c_we      (c_we_s),
        .c_waddr   (c_waddr_s),
        .c_wdata   (c_wdata_s),
        .c_raddr   (c_raddr_s),
        .c_rdata   (c_rdata),
        .h_we      (h_we_s),
        .h_waddr   (h_waddr_s),
        .h_wdata   (h_wdata_s),
        .h_raddr   (h_raddr_s),
        .h_rdata   (h_rdata)
    );

    cchc_store #(
        .AW (AW),
        .HB (HB)
    ) u_store (
        .clk     (clk),
        .c_we    (c_we),
        .c_waddr (c_waddr),
        .c_wdata (c_wdata),
        .c_raddr (c_raddr),
        .c_rdata (c_rdata),
        .h_we    (h_we),
        .h_waddr (h_waddr),
        .h_wdata (h_wdata),
        .h_raddr (h_raddr),
        .h_rdata (h_rdata)
    );

endmodule
